FILE: rtl/phr_trig_pkg.sv
// ----------------------------------------------------------------------------
// Power headroom report trigger package
// Shared widths, operation codes and configuration register indexes.
// ----------------------------------------------------------------------------
package phr_trig_pkg;

	localparam int unsigned TIMER_BITS_DEFAULT = 10;

	localparam int unsigned OP_W       = 3;
	localparam int unsigned PATHLOSS_W = 8;
	localparam int unsigned HEADROOM_W = 7;
	localparam int unsigned LENGTH_W   = 10;
	localparam int unsigned DELTA_W    = 8;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 10;

	// Operation codes carried by a request. Codes 5 to 7 have no meaning.
	typedef enum logic [OP_W-1:0] {
		OP_TICK           = 3'd0,
		OP_PATHLOSS_CHECK = 3'd1,
		OP_UL_GRANT       = 3'd2,
		OP_START_PERIODIC = 3'd3,
		OP_APPLY_CONFIG   = 3'd4
	} op_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE          = 3'd0,
		CFG_PERIODIC_LENGTH = 3'd1,
		CFG_PROHIBIT_LENGTH = 3'd2,
		CFG_PATHLOSS_DELTA  = 3'd3,
		CFG_EXTENDED_FORMAT = 3'd4
	} cfg_idx_t;

endpackage

FILE: rtl/phr_trig_if.sv
// ----------------------------------------------------------------------------
// Power headroom report trigger channels
// Valid/ready channels for the incoming events and the outgoing results.
// ----------------------------------------------------------------------------
interface phr_trig_in_if;
	logic                                  valid;
	logic                                  ready;
	logic [phr_trig_pkg::OP_W-1:0]         operation;
	logic [phr_trig_pkg::PATHLOSS_W-1:0]   pathloss_db;
	logic signed [phr_trig_pkg::HEADROOM_W-1:0] headroom_db;

	modport source (output valid, output operation, output pathloss_db,
		output headroom_db, input ready);
	modport sink (input valid, input operation, input pathloss_db,
		input headroom_db, output ready);
endinterface

interface phr_trig_out_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  report_sent;
	logic signed [phr_trig_pkg::HEADROOM_W-1:0] report_value;
	logic                                  trigger_pending;
	logic                                  extended_out;

	modport source (output valid, output report_sent, output report_value,
		output trigger_pending, output extended_out, input ready);
	modport sink (input valid, input report_sent, input report_value,
		input trigger_pending, input extended_out, output ready);
endinterface

FILE: rtl/power_headroom_report_trigger.sv
// ----------------------------------------------------------------------------
// Power headroom report trigger
// Tracks the periodic and prohibit timers and the pathloss reference and
// decides when an uplink grant carries a power headroom report.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the cmd channel (valid/ready), each holding an operation
// (tick, pathloss check, uplink grant, start periodic, apply config), the
// measured pathloss and the current headroom. Every request produces exactly
// one result on the rpt channel: whether a report was sent, its value, the
// pending-trigger flag after the request and the selected report format.
// A request is accepted at a rising edge with cmd.valid and cmd.ready high.
// The state update and the result are computed in the cycle of acceptance and
// the result is shown from the result register in the next cycle. The block
// takes one request every cycle while the receiver does not stall. The single
// result register decides the rate: cmd.ready is high whenever that register
// is empty or its result is being taken in the same cycle.
// When the receiver stalls, the result register holds its result and cmd.ready
// drops until the result is taken; no request is lost or repeated.
// Configuration registers are written through cfg_we/cfg_index/cfg_data by
// the user only while no request is in flight; the block does not enforce it.
// Reset clears configuration, timers, state flags and the result valid bit.
// ----------------------------------------------------------------------------
module power_headroom_report_trigger #(
	parameter int unsigned TIMER_BITS = phr_trig_pkg::TIMER_BITS_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [phr_trig_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [phr_trig_pkg::CFG_DATA_W-1:0]  cfg_data,
	phr_trig_in_if.sink                          cmd,
	phr_trig_out_if.source                       rpt
);

	// Configuration registers.
	logic                                   enable_q;
	logic [phr_trig_pkg::LENGTH_W-1:0]      periodic_length_q;
	logic [phr_trig_pkg::LENGTH_W-1:0]      prohibit_length_q;
	logic [phr_trig_pkg::DELTA_W-1:0]       pathloss_delta_q;
	logic                                   extended_format_q;

	// Trigger state.
	logic                                   pending_q;
	logic [phr_trig_pkg::PATHLOSS_W-1:0]    last_pathloss_q;
	logic [TIMER_BITS-1:0]                  periodic_count_q;
	logic                                   periodic_running_q;
	logic [TIMER_BITS-1:0]                  prohibit_count_q;
	logic                                   prohibit_running_q;
	logic                                   prohibit_expired_q;

	// Result register.
	logic                                   rpt_valid_q;
	logic                                   report_sent_q;
	logic signed [phr_trig_pkg::HEADROOM_W-1:0] report_value_q;
	logic                                   trigger_pending_q;
	logic                                   extended_out_q;

	// Next-state values.
	logic                                   pending_d;
	logic [phr_trig_pkg::PATHLOSS_W-1:0]    last_pathloss_d;
	logic [TIMER_BITS-1:0]                  periodic_count_d;
	logic                                   periodic_running_d;
	logic [TIMER_BITS-1:0]                  prohibit_count_d;
	logic                                   prohibit_running_d;
	logic                                   prohibit_expired_d;
	logic                                   sent_d;
	logic signed [phr_trig_pkg::HEADROOM_W-1:0] value_d;

	logic                                   accept;
	logic [TIMER_BITS-1:0]                  periodic_len;
	logic [TIMER_BITS-1:0]                  prohibit_len;
	logic [TIMER_BITS-1:0]                  periodic_dec;
	logic [TIMER_BITS-1:0]                  prohibit_dec;
	logic [phr_trig_pkg::PATHLOSS_W-1:0]    pathloss_diff;
	logic                                   pathloss_moved;

	// A new request can enter whenever the result register is free or drains now.
	assign cmd.ready = !rpt_valid_q || rpt.ready;
	assign accept    = cmd.valid && cmd.ready;

	// Timer lengths are taken modulo the counter width.
	assign periodic_len = TIMER_BITS'(periodic_length_q);
	assign prohibit_len = TIMER_BITS'(prohibit_length_q);
	assign periodic_dec = periodic_count_q - TIMER_BITS'(1);
	assign prohibit_dec = prohibit_count_q - TIMER_BITS'(1);

	// The pathloss test needs reporting enabled, a nonzero threshold and a change
	// strictly larger than that threshold.
	assign pathloss_diff = (cmd.pathloss_db >= last_pathloss_q) ?
		(cmd.pathloss_db - last_pathloss_q) : (last_pathloss_q - cmd.pathloss_db);
	assign pathloss_moved = enable_q && (pathloss_delta_q != '0) &&
		(pathloss_diff > pathloss_delta_q);

	always_comb begin
		pending_d          = pending_q;
		last_pathloss_d    = last_pathloss_q;
		periodic_count_d   = periodic_count_q;
		periodic_running_d = periodic_running_q;
		prohibit_count_d   = prohibit_count_q;
		prohibit_running_d = prohibit_running_q;
		prohibit_expired_d = prohibit_expired_q;
		sent_d             = 1'b0;
		value_d            = '0;

		unique case (phr_trig_pkg::op_t'(cmd.operation))
			phr_trig_pkg::OP_TICK: begin
				// Periodic timer first: on expiry, if enabled, it raises the trigger and restarts when its length is nonzero.
				if (periodic_running_q) begin
					periodic_count_d = periodic_dec;
					if (periodic_dec == '0) begin
						periodic_running_d = 1'b0;
						if (enable_q) begin
							pending_d = 1'b1;
							if (periodic_len != '0) begin
								periodic_count_d   = periodic_len;
								periodic_running_d = 1'b1;
							end
						end
					end
				end
				// Prohibit expiry triggers only when the pathloss moved far enough.
				if (prohibit_running_q) begin
					prohibit_count_d = prohibit_dec;
					if (prohibit_dec == '0) begin
						prohibit_running_d = 1'b0;
						prohibit_expired_d = 1'b1;
						if (pathloss_moved) begin
							last_pathloss_d = cmd.pathloss_db;
							pending_d       = 1'b1;
						end
					end
				end
			end
			phr_trig_pkg::OP_PATHLOSS_CHECK: begin
				// The reference follows a large move even while prohibit still runs.
				if (pathloss_moved) begin
					last_pathloss_d = cmd.pathloss_db;
					if (prohibit_expired_q) begin
						pending_d = 1'b1;
					end
				end
			end
			phr_trig_pkg::OP_UL_GRANT: begin
				if (pending_q) begin
					sent_d    = 1'b1;
					value_d   = cmd.headroom_db;
					pending_d = 1'b0;
					if (periodic_len != '0) begin
						periodic_count_d   = periodic_len;
						periodic_running_d = 1'b1;
					end
					if (prohibit_len != '0) begin
						prohibit_count_d   = prohibit_len;
						prohibit_running_d = 1'b1;
						prohibit_expired_d = 1'b0;
					end
				end
			end
			phr_trig_pkg::OP_START_PERIODIC: begin
				if (enable_q && (periodic_len != '0)) begin
					periodic_count_d   = periodic_len;
					periodic_running_d = 1'b1;
				end
			end
			phr_trig_pkg::OP_APPLY_CONFIG: begin
				periodic_count_d   = '0;
				periodic_running_d = 1'b0;
				prohibit_count_d   = '0;
				prohibit_running_d = 1'b0;
				prohibit_expired_d = 1'b0;
				if (enable_q) begin
					if (periodic_len != '0) begin
						periodic_count_d   = periodic_len;
						periodic_running_d = 1'b1;
						pending_d          = 1'b1;
					end
					if (prohibit_len != '0) begin
						prohibit_count_d   = prohibit_len;
						prohibit_running_d = 1'b1;
						pending_d          = 1'b1;
					end
				end
			end
			default: begin
				// Unused codes leave the state alone and report it.
			end
		endcase
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q          <= 1'b0;
			periodic_length_q <= '0;
			prohibit_length_q <= '0;
			pathloss_delta_q  <= '0;
			extended_format_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (phr_trig_pkg::cfg_idx_t'(cfg_index))
				phr_trig_pkg::CFG_ENABLE:          enable_q <= cfg_data[0];
				phr_trig_pkg::CFG_PERIODIC_LENGTH:
					periodic_length_q <= cfg_data[phr_trig_pkg::LENGTH_W-1:0];
				phr_trig_pkg::CFG_PROHIBIT_LENGTH:
					prohibit_length_q <= cfg_data[phr_trig_pkg::LENGTH_W-1:0];
				phr_trig_pkg::CFG_PATHLOSS_DELTA:
					pathloss_delta_q <= cfg_data[phr_trig_pkg::DELTA_W-1:0];
				phr_trig_pkg::CFG_EXTENDED_FORMAT: extended_format_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Trigger state advances on every accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q          <= 1'b0;
			last_pathloss_q    <= '0;
			periodic_count_q   <= '0;
			periodic_running_q <= 1'b0;
			prohibit_count_q   <= '0;
			prohibit_running_q <= 1'b0;
			prohibit_expired_q <= 1'b0;
		end else if (accept) begin
			pending_q          <= pending_d;
			last_pathloss_q    <= last_pathloss_d;
			periodic_count_q   <= periodic_count_d;
			periodic_running_q <= periodic_running_d;
			prohibit_count_q   <= prohibit_count_d;
			prohibit_running_q <= prohibit_running_d;
			prohibit_expired_q <= prohibit_expired_d;
		end
	end

	// Result register: valid is control state, the payload loads on acceptance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_valid_q <= 1'b0;
		end else if (accept) begin
			rpt_valid_q <= 1'b1;
		end else if (rpt.ready) begin
			rpt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			report_sent_q     <= sent_d;
			report_value_q    <= value_d;
			trigger_pending_q <= pending_d;
			extended_out_q    <= extended_format_q;
		end
	end

	assign rpt.valid           = rpt_valid_q;
	assign rpt.report_sent     = report_sent_q;
	assign rpt.report_value    = report_value_q;
	assign rpt.trigger_pending = trigger_pending_q;
	assign rpt.extended_out    = extended_out_q;

endmodule
